FILE: rtl/rom_to_framebuffer_blitter_core_macros.svh
// Assertion macros for the ROM to framebuffer blitter.
// Included by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef ROM_TO_FRAMEBUFFER_BLITTER_CORE_MACROS_SVH
`define ROM_TO_FRAMEBUFFER_BLITTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define RFB_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("rfb: same-cycle check failed");
// Next-cycle implication.
`define RFB_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("rfb: next-cycle check failed");
`else
`define RFB_ASSERT_IMP(name, cond, prop)
`define RFB_ASSERT_NXT(name, cond, prop)
`endif
`endif

FILE: rtl/rfb_pkg.sv
// Shared types, codes and colour expansion functions of the blitter.
// No dependencies; used by every RTL file of the block.
package rfb_pkg;

    localparam int ROM_BANKS_DEF = 8;
    localparam int BANK_BYTES    = 32'h20000;
    localparam int BANK_SHIFT    = 17;
    localparam int PTR_W         = 22;  // holds any address of a 32-bank ROM
    localparam int CLUT_W        = 64;
    localparam int CFG_IDX_W     = 1;
    localparam int COUNT_W       = 17;
    localparam int SLOTS         = 3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_ROM   = 1'b1;

    localparam logic [3:0] REG_SRC_LO = 4'd0;
    localparam logic [3:0] REG_SRC_HI = 4'd1;
    localparam logic [3:0] REG_DEST_X = 4'd2;
    localparam logic [3:0] REG_DEST_Y = 4'd3;
    localparam logic [3:0] REG_SIZE_X = 4'd4;
    localparam logic [3:0] REG_SIZE_Y = 4'd5;
    localparam logic [3:0] REG_DIR    = 4'd6;
    localparam logic [3:0] REG_BANK   = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUT_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUT_HIGH = 1'b1;

    localparam logic [1:0] KIND_ROM_REQ = 2'd0;
    localparam logic [1:0] KIND_PIXEL   = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam int MODE_DIRECT_BIT = 2;
    localparam int MODE_OR_BIT     = 5;
    localparam logic [7:0] BYTE_TRANSPARENT = 8'hff;
    localparam logic [4:0] SND_BANK         = 5'h10;

    typedef struct packed {
        logic [1:0]         kind;
        logic [19:0]        rom_addr;
        logic [8:0]         pix_x;
        logic [7:0]         pix_y;
        logic [23:0]        pix_rgb;
        logic               or_mode;
        logic [COUNT_W-1:0] byte_count;
        logic               last;
    } t_result;

    typedef struct packed {
        logic direct;
        logic or_mode;
        logic dir_x;
    } t_colour_ctl;

    typedef struct packed {
        logic        v1;
        logic        v2;
        logic [23:0] rgb1;
        logic [23:0] rgb2;
        logic        or_mode;
    } t_pix_pair;

    typedef struct packed {
        logic active;
        logic load;
    } t_walk_status;

    typedef struct packed {
        logic [SLOTS-1:0] vld;
    } t_buf_status;

    // Expansions to 8 bits replicate the top bits into the low end.
    function automatic logic [7:0] p6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] p5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [23:0] high_rgb(input logic [7:0] c);
        return {p6({c[2:0], 3'b000}), p5({c[5:3], 2'b00}), p5({c[7:6], 3'b000})};
    endfunction

    function automatic logic [23:0] or_rgb(input logic [7:0] c);
        return {p6({3'b000, c[2:0]}), p5({3'b000, c[4:3]}), p5({2'b00, c[7:5]})};
    endfunction

endpackage

FILE: rtl/rfb_colour.sv
// Colour unit: lookup table registers and the byte to pixel-pair conversion.
// Depends on rfb_pkg.
module rfb_colour (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfb_pkg::CLUT_W-1:0]     i_cfg_data,
    input  logic [7:0]                     i_rom_byte,
    input  rfb_pkg::t_colour_ctl           i_ctl,
    output rfb_pkg::t_pix_pair             o_pix
);

    logic [rfb_pkg::CLUT_W-1:0]   r_clut_low;
    logic [rfb_pkg::CLUT_W-1:0]   r_clut_high;
    logic [2*rfb_pkg::CLUT_W-1:0] w_clut;
    logic [3:0]                   w_nib1;
    logic [3:0]                   w_nib2;
    logic [7:0]                   w_ent1;
    logic [7:0]                   w_ent2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clut_low  <= '0;
            r_clut_high <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rfb_pkg::CFG_CLUT_LOW:  r_clut_low  <= i_cfg_data;
                rfb_pkg::CFG_CLUT_HIGH: r_clut_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_clut = {r_clut_high, r_clut_low};

    // Walking left to right swaps which nibble lands on the left pixel.
    assign w_nib1 = i_ctl.dir_x ? i_rom_byte[3:0] : i_rom_byte[7:4];
    assign w_nib2 = i_ctl.dir_x ? i_rom_byte[7:4] : i_rom_byte[3:0];
    assign w_ent1 = w_clut[{w_nib1, 3'b000} +: 8];
    assign w_ent2 = w_clut[{w_nib2, 3'b000} +: 8];

    always_comb begin
        o_pix = '0;
        if (i_ctl.direct) begin
            o_pix.v1      = (i_rom_byte != rfb_pkg::BYTE_TRANSPARENT);
            o_pix.v2      = o_pix.v1;
            o_pix.or_mode = i_ctl.or_mode;
            o_pix.rgb1    = i_ctl.or_mode ? rfb_pkg::or_rgb(i_rom_byte)
                                          : rfb_pkg::high_rgb(i_rom_byte);
            o_pix.rgb2    = o_pix.rgb1;
        end else begin
            // The table holds inverted colours; a zero entry is see-through.
            o_pix.v1   = (w_ent1 != 8'h00);
            o_pix.v2   = (w_ent2 != 8'h00);
            o_pix.rgb1 = rfb_pkg::high_rgb(~w_ent1);
            o_pix.rgb2 = rfb_pkg::high_rgb(~w_ent2);
        end
    end

endmodule

FILE: rtl/rfb_walk.sv
// Blitter register file and rectangle walker; builds the results of one beat.
// Depends on rfb_pkg; takes pixel colours from rfb_colour.
module rfb_walk #(
    parameter int ROM_BANKS = rfb_pkg::ROM_BANKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_req_type,
    input  logic [3:0]                         i_reg_offset,
    input  logic [7:0]                         i_reg_data,
    input  logic                               i_sound_bank_bit,
    input  rfb_pkg::t_pix_pair                 i_pix,
    output rfb_pkg::t_colour_ctl               o_ctl,
    output rfb_pkg::t_result [rfb_pkg::SLOTS-1:0] o_slots,
    output logic [rfb_pkg::SLOTS-1:0]          o_slot_vld,
    output rfb_pkg::t_walk_status              o_status
);

    localparam int PW = rfb_pkg::PTR_W;
    localparam logic [PW:0] ROM_LAST = (PW+1)'(ROM_BANKS * rfb_pkg::BANK_BYTES - 1);
    localparam logic [5:0]  BANKS_6  = 6'(ROM_BANKS);
    localparam logic [3:0]  BANK_MSK = 4'(ROM_BANKS - 1);

    logic [15:0]                 r_src,    n_src;
    logic [7:0]                  r_dest_x, n_dest_x;
    logic [7:0]                  r_dest_y, n_dest_y;
    logic [7:0]                  r_size_x, n_size_x;
    logic [7:0]                  r_size_y, n_size_y;
    logic [1:0]                  r_dir,    n_dir;
    logic [4:0]                  r_bank,   n_bank;
    logic [7:0]                  r_mode,   n_mode;
    logic [7:0]                  r_cur_x,  n_cur_x;
    logic [7:0]                  r_cur_y,  n_cur_y;
    logic [7:0]                  r_cnt_x,  n_cnt_x;
    logic [7:0]                  r_cnt_y,  n_cnt_y;
    logic [PW-1:0]               r_ptr,    n_ptr;
    logic [rfb_pkg::COUNT_W-1:0] r_walked, n_walked;
    logic                        r_active, n_active;

    logic [4:0]  w_bank_start;
    logic [PW:0] w_ptr_start;
    logic [PW:0] w_ptr_inc;
    logic [PW:0] w_ptr_raw;
    logic [PW-1:0] w_ptr_chk;
    logic [3:0]  w_bank_sel;
    logic [7:0]  w_start_x;
    logic [7:0]  w_start_cnt_x;

    assign w_bank_start  = r_bank | (i_sound_bank_bit ? rfb_pkg::SND_BANK : 5'h00);
    assign w_ptr_start   = ((PW+1)'(w_bank_start) << rfb_pkg::BANK_SHIFT)
                         + (PW+1)'({r_src, 1'b0});
    assign w_ptr_inc     = {1'b0, r_ptr} + (PW+1)'(1);
    assign w_bank_sel    = {i_reg_data[7:6], 2'b00} + {2'b00, i_reg_data[1:0]};
    assign w_start_x     = r_dest_x + r_size_x;
    assign w_start_cnt_x = r_dir[0] ? ~r_size_x : r_size_x;

    // Both starting and stepping addresses wrap to zero past the ROM end.
    always_comb begin
        w_ptr_raw = (r_active && (i_req_type == rfb_pkg::REQ_ROM)) ? w_ptr_inc : w_ptr_start;
        w_ptr_chk = (w_ptr_raw > ROM_LAST) ? '0 : w_ptr_raw[PW-1:0];
    end

    assign o_ctl.direct  = r_mode[rfb_pkg::MODE_DIRECT_BIT];
    assign o_ctl.or_mode = r_mode[rfb_pkg::MODE_OR_BIT];
    assign o_ctl.dir_x   = r_dir[0];

    always_comb begin
        n_src    = r_src;
        n_dest_x = r_dest_x;
        n_dest_y = r_dest_y;
        n_size_x = r_size_x;
        n_size_y = r_size_y;
        n_dir    = r_dir;
        n_bank   = r_bank;
        n_mode   = r_mode;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_cnt_x  = r_cnt_x;
        n_cnt_y  = r_cnt_y;
        n_ptr    = r_ptr;
        n_walked = r_walked;
        n_active = r_active;
        o_slots    = '0;
        o_slot_vld = '0;

        if (i_req_type == rfb_pkg::REQ_WRITE) begin
            if (!r_active) begin
                unique case (i_reg_offset)
                    rfb_pkg::REG_SRC_LO: n_src[7:0]  = i_reg_data;
                    rfb_pkg::REG_SRC_HI: n_src[15:8] = i_reg_data;
                    rfb_pkg::REG_DEST_X: n_dest_x    = i_reg_data;
                    rfb_pkg::REG_DEST_Y: n_dest_y    = i_reg_data;
                    rfb_pkg::REG_SIZE_X: n_size_x    = i_reg_data;
                    rfb_pkg::REG_SIZE_Y: begin
                        n_size_y = i_reg_data;
                        n_bank   = w_bank_start;
                        n_cur_x  = w_start_x;
                        n_cur_y  = r_dest_y + i_reg_data;
                        n_cnt_x  = w_start_cnt_x;
                        n_cnt_y  = r_dir[1] ? ~i_reg_data : i_reg_data;
                        n_ptr    = w_ptr_chk;
                        n_walked = '0;
                        n_active = 1'b1;
                        o_slots[2].kind     = rfb_pkg::KIND_ROM_REQ;
                        o_slots[2].rom_addr = w_ptr_chk[19:0];
                        o_slots[2].last     = 1'b1;
                        o_slot_vld[2]       = 1'b1;
                    end
                    rfb_pkg::REG_DIR:    n_dir = i_reg_data[1:0];
                    rfb_pkg::REG_BANK: begin
                        n_bank = ({2'b00, w_bank_sel} >= BANKS_6)
                               ? {1'b0, w_bank_sel & BANK_MSK} : {1'b0, w_bank_sel};
                        n_mode = i_reg_data;
                    end
                    default: ;
                endcase
            end
        end else if (r_active) begin
            o_slots[0].kind    = rfb_pkg::KIND_PIXEL;
            o_slots[0].pix_x   = {r_cur_x, 1'b0};
            o_slots[0].pix_y   = r_cur_y;
            o_slots[0].pix_rgb = i_pix.rgb1;
            o_slots[0].or_mode = i_pix.or_mode;
            o_slots[1].kind    = rfb_pkg::KIND_PIXEL;
            o_slots[1].pix_x   = {r_cur_x, 1'b1};
            o_slots[1].pix_y   = r_cur_y;
            o_slots[1].pix_rgb = i_pix.rgb2;
            o_slots[1].or_mode = i_pix.or_mode;
            o_slot_vld[0] = i_pix.v1;
            o_slot_vld[1] = i_pix.v2;
            o_slot_vld[2] = 1'b1;
            o_slots[2].last = 1'b1;

            n_walked = r_walked + rfb_pkg::COUNT_W'(1);
            n_ptr    = w_ptr_chk;
            if (r_cnt_x != 8'h00) begin
                n_cnt_x = r_cnt_x - 8'h01;
                n_cur_x = r_dir[0] ? r_cur_x + 8'h01 : r_cur_x - 8'h01;
            end else if (r_cnt_y != 8'h00) begin
                n_cnt_y = r_cnt_y - 8'h01;
                n_cur_y = r_dir[1] ? r_cur_y + 8'h01 : r_cur_y - 8'h01;
                n_cur_x = w_start_x;
                n_cnt_x = w_start_cnt_x;
            end else begin
                n_active = 1'b0;
            end

            if (n_active) begin
                o_slots[2].kind     = rfb_pkg::KIND_ROM_REQ;
                o_slots[2].rom_addr = w_ptr_chk[19:0];
            end else begin
                o_slots[2].kind       = rfb_pkg::KIND_DONE;
                o_slots[2].byte_count = n_walked;
            end
        end
    end

    assign o_status.active = r_active;
    assign o_status.load   = i_accept && (o_slot_vld != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src    <= '0;
            r_dest_x <= '0;
            r_dest_y <= '0;
            r_size_x <= '0;
            r_size_y <= '0;
            r_dir    <= '0;
            r_bank   <= '0;
            r_mode   <= '0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_cnt_x  <= '0;
            r_cnt_y  <= '0;
            r_ptr    <= '0;
            r_walked <= '0;
            r_active <= 1'b0;
        end else if (i_accept) begin
            r_src    <= n_src;
            r_dest_x <= n_dest_x;
            r_dest_y <= n_dest_y;
            r_size_x <= n_size_x;
            r_size_y <= n_size_y;
            r_dir    <= n_dir;
            r_bank   <= n_bank;
            r_mode   <= n_mode;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_cnt_x  <= n_cnt_x;
            r_cnt_y  <= n_cnt_y;
            r_ptr    <= n_ptr;
            r_walked <= n_walked;
            r_active <= n_active;
        end
    end

endmodule

FILE: rtl/rfb_outbuf.sv
// Result register of three slots, drained one result per clock in slot order unless stalled.
// Depends on rfb_pkg.
module rfb_outbuf (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  rfb_pkg::t_result [rfb_pkg::SLOTS-1:0] i_slots,
    input  logic [rfb_pkg::SLOTS-1:0]             i_slot_vld,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output rfb_pkg::t_result                      o_result,
    output logic                                  o_in_stall,
    output rfb_pkg::t_buf_status                  o_status
);

    rfb_pkg::t_result [rfb_pkg::SLOTS-1:0] r_slots;
    logic [rfb_pkg::SLOTS-1:0]             r_vld, n_vld;
    logic [rfb_pkg::SLOTS-1:0]             w_sel;
    logic [rfb_pkg::SLOTS-1:0]             w_left;
    logic                                  w_take;

    // Lowest pending slot goes first.
    assign w_sel       = r_vld & (~r_vld + rfb_pkg::SLOTS'(1));
    assign o_out_valid = (r_vld != '0);
    assign w_take      = o_out_valid && !i_out_stall;
    assign w_left      = w_take ? (r_vld & ~w_sel) : r_vld;
    // A new beat may enter as the last pending result leaves.
    assign o_in_stall  = (w_left != '0);
    assign n_vld       = i_load ? i_slot_vld : w_left;
    assign o_status.vld = r_vld;

    always_comb begin
        priority if (w_sel[0]) begin
            o_result = r_slots[0];
        end else if (w_sel[1]) begin
            o_result = r_slots[1];
        end else begin
            o_result = r_slots[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slots <= i_slots;
        end
    end

endmodule

FILE: rtl/rom_to_framebuffer_blitter_core.sv
// Register-programmed blitter that turns graphics ROM bytes into framebuffer pixel writes.
// Each input beat is handled in the clock it is accepted and its results (a ROM read
// request, up to two pixel writes, or a finish report with the byte count) are loaded
// into a three-slot result register that emits one result per clock unless the output
// is stalled. A ROM-byte beat yields up to three results, which leave through the
// single output port in slot order; the next beat is taken in the same cycle as the
// last pending result leaves. ROM_BANKS (1 to 32) sets the ROM size in 128 KiB banks,
// at which read addresses wrap to zero. Depends on rfb_pkg.
`include "rom_to_framebuffer_blitter_core_macros.svh"

module rom_to_framebuffer_blitter_core #(
    parameter int ROM_BANKS = rfb_pkg::ROM_BANKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rfb_pkg::CLUT_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [3:0]                        i_reg_offset,
    input  logic [7:0]                        i_reg_data,
    input  logic [7:0]                        i_rom_byte,
    input  logic                              i_sound_bank_bit,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_out_kind,
    output logic [19:0]                       o_rom_addr,
    output logic [8:0]                        o_pix_x,
    output logic [7:0]                        o_pix_y,
    output logic [23:0]                       o_pix_rgb,
    output logic                              o_or_mode,
    output logic [rfb_pkg::COUNT_W-1:0]       o_byte_count,
    output logic                              o_last
);

    logic                                  w_in_accept;
    rfb_pkg::t_colour_ctl                  w_ctl;
    rfb_pkg::t_pix_pair                    w_pix;
    rfb_pkg::t_result [rfb_pkg::SLOTS-1:0] w_slots;
    logic [rfb_pkg::SLOTS-1:0]             w_slot_vld;
    rfb_pkg::t_walk_status                 w_walk_st;
    rfb_pkg::t_buf_status                  w_buf_st;
    rfb_pkg::t_result                      w_result;

    assign w_in_accept = i_in_valid && !o_in_stall;

    rfb_colour u_colour (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rom_byte  (i_rom_byte),
        .i_ctl       (w_ctl),
        .o_pix       (w_pix)
    );

    rfb_walk #(
        .ROM_BANKS (ROM_BANKS)
    ) u_walk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_in_accept),
        .i_req_type       (i_req_type),
        .i_reg_offset     (i_reg_offset),
        .i_reg_data       (i_reg_data),
        .i_sound_bank_bit (i_sound_bank_bit),
        .i_pix            (w_pix),
        .o_ctl            (w_ctl),
        .o_slots          (w_slots),
        .o_slot_vld       (w_slot_vld),
        .o_status         (w_walk_st)
    );

    rfb_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_walk_st.load),
        .i_slots     (w_slots),
        .i_slot_vld  (w_slot_vld),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (w_result),
        .o_in_stall  (o_in_stall),
        .o_status    (w_buf_st)
    );

    assign o_out_kind   = w_result.kind;
    assign o_rom_addr   = w_result.rom_addr;
    assign o_pix_x      = w_result.pix_x;
    assign o_pix_y      = w_result.pix_y;
    assign o_pix_rgb    = w_result.pix_rgb;
    assign o_or_mode    = w_result.or_mode;
    assign o_byte_count = w_result.byte_count;
    assign o_last       = w_result.last;

    // Input is only let in when at most one result is still pending.
    `RFB_ASSERT_IMP(a_room_on_accept, !o_in_stall, $countones(w_buf_st.vld) <= 1)
    // A loaded beat must show a result in the following cycle.
    `RFB_ASSERT_NXT(a_load_shows, w_walk_st.load, o_out_valid)
    // A finish report can only leave once the walker has gone idle.
    `RFB_ASSERT_IMP(a_done_idle, o_out_valid && (o_out_kind == rfb_pkg::KIND_DONE),
                    !w_walk_st.active)
    // Register writes during a walk are dropped without results.
    `RFB_ASSERT_IMP(a_busy_write,
                    w_in_accept && w_walk_st.active && (i_req_type == rfb_pkg::REQ_WRITE),
                    !w_walk_st.load)

endmodule
